// ===== src/qsst_pkg.sv =====
// Shared types and codes for the QUIC stream state tracker.
// Used by qsst_logic and quic_stream_state_tracker; no dependencies.
package qsst_pkg;

  typedef enum logic [2:0] {
    S_INIT       = 3'd0,
    S_READY      = 3'd1,
    S_SEND       = 3'd2,
    S_DATASENT   = 3'd3,
    S_DATARECVD  = 3'd4,
    S_RESETSENT  = 3'd5,
    S_RESETRECVD = 3'd6
  } send_state_t;

  typedef enum logic [2:0] {
    R_INIT       = 3'd0,
    R_RECV       = 3'd1,
    R_SIZEKNOWN  = 3'd2,
    R_DATARECVD  = 3'd3,
    R_DATAREAD   = 3'd4,
    R_RESETRECVD = 3'd5,
    R_RESETREAD  = 3'd6
  } recv_state_t;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_OPEN        = 3'd1,
    ST_HALF_REMOTE = 3'd2,
    ST_HALF_LOCAL  = 3'd3,
    ST_CLOSED      = 3'd4,
    ST_INVALID     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    FR_STREAM  = 3'd0,
    FR_SDB     = 3'd1,
    FR_RESET   = 3'd2,
    FR_STOP    = 3'd3,
    FR_MAXDATA = 3'd4,
    FR_OTHER   = 3'd5
  } frame_t;

  typedef enum logic [2:0] {
    EV_SENT     = 3'd0,
    EV_RECEIVED = 3'd1,
    EV_ACK      = 3'd2,
    EV_READ     = 3'd3,
    EV_END      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0] kind;
    frame_t     frame;
    logic       fin;
    logic       in_complete;
    logic       out_complete;
    logic       out_cancelled;
  } item_t;

  typedef struct packed {
    send_state_t send_part;
    recv_state_t recv_part;
    status_t     stream_status;
    logic        may_send;
    logic        may_receive;
  } result_t;

endpackage

// ===== src/quic_stream_state_tracker.sv =====
// QUIC stream state tracker: one event in, one result out. A beat is held in
// s1_item and its result in out_res; a new beat is taken every cycle unless
// out_stall holds a full pipeline. The only loop is the update of the send and
// receive state registers from qsst_logic. Synchronous active-high reset clears
// both stage valids, sets send to Ready, receive to Init. Uses qsst_pkg, qsst_logic.
module quic_stream_state_tracker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [2:0] frame_type,
  input  logic       fin,
  input  logic       in_complete,
  input  logic       out_complete,
  input  logic       out_cancelled,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] send_part,
  output logic [2:0] recv_part,
  output logic [2:0] stream_status,
  output logic       may_send,
  output logic       may_receive
);

  qsst_pkg::item_t       item_in;
  qsst_pkg::item_t       s1_item;
  logic                  s1_valid;
  qsst_pkg::send_state_t send_state;
  qsst_pkg::recv_state_t recv_state;
  qsst_pkg::send_state_t send_state_next;
  qsst_pkg::recv_state_t recv_state_next;
  qsst_pkg::result_t     res_next;
  qsst_pkg::result_t     out_res;
  logic                  out_load;
  logic                  advance;
  logic                  accept;

  // codes above "other" act as "other"
  always_comb begin
    item_in.kind          = kind;
    item_in.frame         = (frame_type > 3'(qsst_pkg::FR_OTHER)) ? qsst_pkg::FR_OTHER
                                                                  : qsst_pkg::frame_t'(frame_type);
    item_in.fin           = fin;
    item_in.in_complete   = in_complete;
    item_in.out_complete  = out_complete;
    item_in.out_cancelled = out_cancelled;
  end

  assign out_load = !out_valid || !out_stall;
  assign advance  = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;
  assign accept   = in_valid && !in_stall;

  qsst_logic u_logic (
    .item      (s1_item),
    .send_cur  (send_state),
    .recv_cur  (recv_state),
    .send_next (send_state_next),
    .recv_next (recv_state_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      send_state <= qsst_pkg::S_READY;
      recv_state <= qsst_pkg::R_INIT;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;
      if (out_load) out_valid <= s1_valid;
      // commit state only when the beat moves into the result register
      if (advance) begin
        send_state <= send_state_next;
        recv_state <= recv_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_item <= item_in;
    if (advance) out_res <= res_next;
  end

  assign send_part     = out_res.send_part;
  assign recv_part     = out_res.recv_part;
  assign stream_status = out_res.stream_status;
  assign may_send      = out_res.may_send;
  assign may_receive   = out_res.may_receive;

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.send_part == send_state && out_res.recv_part == recv_state))
    else $error("shown result does not match committed state");

  a_send_never_init: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> send_state != qsst_pkg::S_INIT)
    else $error("send part returned to Init");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while pipeline can move");

endmodule

// ===== src/qsst_logic.sv =====
// Next-state and result logic for one stream event.
// Purely combinational; depends on qsst_pkg.
module qsst_logic (
  input  qsst_pkg::item_t       item,
  input  qsst_pkg::send_state_t send_cur,
  input  qsst_pkg::recv_state_t recv_cur,
  output qsst_pkg::send_state_t send_next,
  output qsst_pkg::recv_state_t recv_next,
  output qsst_pkg::result_t     res
);

  function automatic qsst_pkg::status_t combined(qsst_pkg::send_state_t sp,
                                                 qsst_pkg::recv_state_t rp);
    logic r_open;
    logic r_done;
    qsst_pkg::status_t st;
    r_open = (rp inside {qsst_pkg::R_RECV, qsst_pkg::R_SIZEKNOWN});
    r_done = (rp inside {qsst_pkg::R_DATARECVD, qsst_pkg::R_DATAREAD,
                         qsst_pkg::R_RESETRECVD, qsst_pkg::R_RESETREAD});
    st = qsst_pkg::ST_INVALID;
    if (sp == qsst_pkg::S_READY || rp == qsst_pkg::R_INIT) begin
      st = qsst_pkg::ST_IDLE;
    end else if (sp inside {qsst_pkg::S_SEND, qsst_pkg::S_DATASENT}) begin
      if (r_open) st = qsst_pkg::ST_OPEN;
      else if (r_done) st = qsst_pkg::ST_HALF_REMOTE;
    end else if (sp inside {qsst_pkg::S_DATARECVD, qsst_pkg::S_RESETSENT,
                            qsst_pkg::S_RESETRECVD}) begin
      if (r_open) st = qsst_pkg::ST_HALF_LOCAL;
      else if (r_done) st = qsst_pkg::ST_CLOSED;
    end
    return st;
  endfunction

  qsst_pkg::frame_t t;
  logic             opens;
  logic             ms;
  logic             mr;
  qsst_pkg::send_state_t s;
  qsst_pkg::recv_state_t r;

  assign t     = item.frame;
  assign opens = (t inside {qsst_pkg::FR_STREAM, qsst_pkg::FR_SDB, qsst_pkg::FR_RESET});

  // Permissions are judged on the states before the update.
  always_comb begin
    ms = 1'b0;
    if (opens) begin
      if (send_cur inside {qsst_pkg::S_READY, qsst_pkg::S_SEND}) begin
        ms = 1'b1;
      end else if ((send_cur inside {qsst_pkg::S_DATASENT, qsst_pkg::S_RESETSENT}) &&
                   t == qsst_pkg::FR_RESET) begin
        ms = 1'b1;
      end
    end
    if (t == qsst_pkg::FR_MAXDATA && recv_cur == qsst_pkg::R_RECV) ms = 1'b1;
    if (t == qsst_pkg::FR_STOP && recv_cur != qsst_pkg::R_RESETRECVD &&
        recv_cur != qsst_pkg::R_RESETREAD) ms = 1'b1;
    mr = opens || t == qsst_pkg::FR_STOP ||
         (t == qsst_pkg::FR_MAXDATA && send_cur != qsst_pkg::S_INIT);
  end

  always_comb begin
    s = send_cur;
    r = recv_cur;
    case (item.kind)
      qsst_pkg::EV_SENT: begin
        if (s == qsst_pkg::S_READY && opens) s = qsst_pkg::S_SEND;
        if (s == qsst_pkg::S_SEND) begin
          if (t == qsst_pkg::FR_STREAM && item.fin) s = qsst_pkg::S_DATASENT;
          else if (t == qsst_pkg::FR_RESET) s = qsst_pkg::S_RESETSENT;
        end else if (s == qsst_pkg::S_DATASENT) begin
          if (t == qsst_pkg::FR_RESET) s = qsst_pkg::S_RESETSENT;
        end
        // a send part still in Ready opens the receive part
        if (s == qsst_pkg::S_READY && r == qsst_pkg::R_INIT) r = qsst_pkg::R_RECV;
      end
      qsst_pkg::EV_RECEIVED: begin
        if (r == qsst_pkg::R_INIT && opens) r = qsst_pkg::R_RECV;
        if (r == qsst_pkg::R_RECV) begin
          if (t == qsst_pkg::FR_STREAM) begin
            if (item.fin) r = item.in_complete ? qsst_pkg::R_DATARECVD
                                               : qsst_pkg::R_SIZEKNOWN;
          end else if (t == qsst_pkg::FR_RESET) begin
            r = qsst_pkg::R_RESETRECVD;
          end
        end else if (r == qsst_pkg::R_SIZEKNOWN) begin
          if (t == qsst_pkg::FR_STREAM && item.in_complete) r = qsst_pkg::R_DATARECVD;
          else if (t == qsst_pkg::FR_RESET) r = qsst_pkg::R_RESETRECVD;
        end
        if (s == qsst_pkg::S_READY && r == qsst_pkg::R_RECV) s = qsst_pkg::S_SEND;
      end
      qsst_pkg::EV_ACK: begin
        if (item.out_complete) s = qsst_pkg::S_DATARECVD;
        else if (item.out_cancelled) s = qsst_pkg::S_RESETRECVD;
      end
      qsst_pkg::EV_READ: begin
        if (item.in_complete) r = qsst_pkg::R_DATAREAD;
      end
      qsst_pkg::EV_END: begin
        r = qsst_pkg::R_RESETREAD;
      end
      default: begin
      end
    endcase
  end

  assign send_next         = s;
  assign recv_next         = r;
  assign res.send_part     = s;
  assign res.recv_part     = r;
  assign res.stream_status = combined(s, r);
  assign res.may_send      = ms;
  assign res.may_receive   = mr;

endmodule
